/* design/vfwd_pkg.sv */
package vfwd_pkg;

    // element data types
    localparam logic [2:0] TY_FLOAT1 = 3'd0;
    localparam logic [2:0] TY_FLOAT2 = 3'd1;
    localparam logic [2:0] TY_FLOAT3 = 3'd2;
    localparam logic [2:0] TY_FLOAT4 = 3'd3;
    localparam logic [2:0] TY_COLOR  = 3'd4;
    localparam logic [2:0] TY_UBYTE4 = 3'd5;
    localparam logic [2:0] TY_END    = 3'd6;

    // element usages
    localparam logic [3:0] US_POS    = 4'd0;
    localparam logic [3:0] US_POST   = 4'd1;
    localparam logic [3:0] US_WEIGHT = 4'd2;
    localparam logic [3:0] US_INDEX  = 4'd3;
    localparam logic [3:0] US_NORMAL = 4'd4;
    localparam logic [3:0] US_PSIZE  = 4'd5;
    localparam logic [3:0] US_COLOR  = 4'd6;
    localparam logic [3:0] US_TEX    = 4'd7;
    localparam logic [3:0] US_END    = 4'd8;

    // fixed element slots, in list order
    localparam int         SLOTS    = 7;
    localparam logic [2:0] SL_POS   = 3'd0;
    localparam logic [2:0] SL_WGT   = 3'd1;
    localparam logic [2:0] SL_IDX   = 3'd2;
    localparam logic [2:0] SL_NRM   = 3'd3;
    localparam logic [2:0] SL_PSZ   = 3'd4;
    localparam logic [2:0] SL_DIFF  = 3'd5;
    localparam logic [2:0] SL_SPEC  = 3'd6;

    // blend codes (format word bits 3:1)
    localparam logic [2:0] BL_FIRST = 3'd3;
    localparam logic [2:0] BL_TWO   = 3'd4;
    localparam logic [2:0] BL_FIVE  = 3'd7;

    // descriptor queue between front and back
    localparam int DQ_AW    = 1;
    localparam int DQ_DEPTH = 2 ** DQ_AW;

    typedef struct packed {
        logic [SLOTS-1:0] present;
        logic [2:0]       pos_type;
        logic [3:0]       pos_usage;
        logic [2:0]       wgt_type;
        logic [2:0]       idx_type;
        logic [3:0]       tex_count;
        logic [15:0]      tex_codes;
    } t_desc;

    typedef struct packed {
        logic [2:0] etype;
        logic [3:0] usage;
        logic [3:0] uidx;
        logic [8:0] offset;
        logic       last;
    } t_elem;

    function automatic logic [2:0] tex_type(input logic [1:0] code);
        logic [2:0] t;
        unique case (code)
            2'd0:    t = TY_FLOAT2;
            2'd1:    t = TY_FLOAT3;
            2'd2:    t = TY_FLOAT4;
            default: t = TY_FLOAT1;
        endcase
        return t;
    endfunction

    // size in bytes of one element of the given type
    function automatic logic [4:0] type_bytes(input logic [2:0] t);
        logic [2:0] n;
        n = {1'b0, t[1:0]} + 3'd1;
        if (t <= TY_FLOAT4) begin
            return {n, 2'b00};
        end
        return 5'd4;
    endfunction

endpackage

/* design/vfwd_front.sv */
module vfwd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [31:0]         i_format_word,
    output logic                o_full,
    input  logic                i_q_full,
    output logic                o_q_push,
    output vfwd_pkg::t_desc     o_q_data
);

    logic            r_valid;
    logic            n_valid;
    vfwd_pkg::t_desc r_desc;
    vfwd_pkg::t_desc n_desc;

    logic [2:0] code;
    logic       has_pos;
    logic       blend_on;
    logic       lb_color;
    logic       lb_ubyte;
    logic       two_color;
    logic       has_idx;
    logic [2:0] nblend;
    logic       accept;

    assign code      = i_format_word[3:1];
    assign has_pos   = (|code) | i_format_word[14];
    assign blend_on  = code >= vfwd_pkg::BL_FIRST;
    assign lb_color  = i_format_word[15];
    assign lb_ubyte  = i_format_word[12];
    assign two_color = (code == vfwd_pkg::BL_TWO) && lb_color;
    assign has_idx   = blend_on && ((code == vfwd_pkg::BL_FIVE) || lb_color || lb_ubyte);

    // weight count: code 3 gives one, up to five for code 7, less one with an index
    always_comb begin
        nblend = 3'd0;
        if (blend_on) begin
            nblend = code - 3'd2 - {2'b00, has_idx};
        end
    end

    always_comb begin
        n_desc = '0;
        n_desc.present[vfwd_pkg::SL_POS]  = has_pos;
        n_desc.present[vfwd_pkg::SL_WGT]  = blend_on && (nblend != 3'd0);
        n_desc.present[vfwd_pkg::SL_IDX]  = has_idx;
        n_desc.present[vfwd_pkg::SL_NRM]  = i_format_word[4];
        n_desc.present[vfwd_pkg::SL_PSZ]  = i_format_word[5];
        n_desc.present[vfwd_pkg::SL_DIFF] = i_format_word[6];
        n_desc.present[vfwd_pkg::SL_SPEC] = i_format_word[7];

        if (!blend_on && i_format_word[2]) begin
            n_desc.pos_type  = vfwd_pkg::TY_FLOAT4;
            n_desc.pos_usage = vfwd_pkg::US_POST;
        end else if (!blend_on && i_format_word[1] && i_format_word[14]) begin
            n_desc.pos_type  = vfwd_pkg::TY_FLOAT4;
            n_desc.pos_usage = vfwd_pkg::US_POS;
        end else begin
            n_desc.pos_type  = vfwd_pkg::TY_FLOAT3;
            n_desc.pos_usage = vfwd_pkg::US_POS;
        end

        if (two_color) begin
            n_desc.wgt_type = vfwd_pkg::TY_COLOR;
        end else begin
            n_desc.wgt_type = nblend - 3'd1;
        end

        if (lb_ubyte || two_color) begin
            n_desc.idx_type = vfwd_pkg::TY_UBYTE4;
        end else if (lb_color) begin
            n_desc.idx_type = vfwd_pkg::TY_COLOR;
        end else begin
            n_desc.idx_type = vfwd_pkg::TY_FLOAT1;
        end

        n_desc.tex_count = i_format_word[11:8];
        n_desc.tex_codes = i_format_word[31:16];
    end

    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_desc;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

/* design/vfwd_desc_q.sv */
module vfwd_desc_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vfwd_pkg::t_desc     i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output vfwd_pkg::t_desc     o_data
);

    vfwd_pkg::t_desc                r_mem [vfwd_pkg::DQ_DEPTH];
    logic [vfwd_pkg::DQ_AW-1:0]     r_wp;
    logic [vfwd_pkg::DQ_AW-1:0]     r_rp;
    logic [vfwd_pkg::DQ_AW:0]       r_count;
    logic [vfwd_pkg::DQ_AW:0]       n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = r_count == (vfwd_pkg::DQ_AW+1)'(vfwd_pkg::DQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* design/vfwd_back.sv */
module vfwd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  vfwd_pkg::t_desc     i_q_data,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output vfwd_pkg::t_elem     o_elem
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_back_state;

    t_back_state                 r_state;
    t_back_state                 n_state;
    vfwd_pkg::t_desc             r_desc;
    logic [vfwd_pkg::SLOTS-1:0]  r_pend;
    logic [3:0]                  r_tex;
    logic [15:0]                 r_codes;
    logic [8:0]                  r_offset;
    logic                        r_out_valid;
    vfwd_pkg::t_elem             r_out;

    logic [2:0]                  sel;
    vfwd_pkg::t_elem             elem;
    logic                        fixed_phase;
    logic                        tex_phase;
    logic                        adv;
    logic                        emit_end;
    logic                        load;

    assign fixed_phase = |r_pend;
    assign tex_phase   = !fixed_phase && (r_tex != r_desc.tex_count);

    // lowest pending fixed slot
    always_comb begin
        sel = '0;
        for (int k = vfwd_pkg::SLOTS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                sel = 3'(k);
            end
        end
    end

    always_comb begin
        elem        = '0;
        elem.offset = r_offset;
        if (fixed_phase) begin
            unique case (sel)
                vfwd_pkg::SL_POS: begin
                    elem.etype = r_desc.pos_type;
                    elem.usage = r_desc.pos_usage;
                end
                vfwd_pkg::SL_WGT: begin
                    elem.etype = r_desc.wgt_type;
                    elem.usage = vfwd_pkg::US_WEIGHT;
                end
                vfwd_pkg::SL_IDX: begin
                    elem.etype = r_desc.idx_type;
                    elem.usage = vfwd_pkg::US_INDEX;
                end
                vfwd_pkg::SL_NRM: begin
                    elem.etype = vfwd_pkg::TY_FLOAT3;
                    elem.usage = vfwd_pkg::US_NORMAL;
                end
                vfwd_pkg::SL_PSZ: begin
                    elem.etype = vfwd_pkg::TY_FLOAT1;
                    elem.usage = vfwd_pkg::US_PSIZE;
                end
                vfwd_pkg::SL_DIFF: begin
                    elem.etype = vfwd_pkg::TY_COLOR;
                    elem.usage = vfwd_pkg::US_COLOR;
                end
                vfwd_pkg::SL_SPEC: begin
                    elem.etype = vfwd_pkg::TY_COLOR;
                    elem.usage = vfwd_pkg::US_COLOR;
                    elem.uidx  = 4'd1;
                end
                default: begin
                    elem.etype = vfwd_pkg::TY_END;
                    elem.usage = vfwd_pkg::US_END;
                end
            endcase
        end else if (tex_phase) begin
            elem.etype = vfwd_pkg::tex_type(r_codes[1:0]);
            elem.usage = vfwd_pkg::US_TEX;
            elem.uidx  = r_tex;
        end else begin
            elem.etype  = vfwd_pkg::TY_END;
            elem.usage  = vfwd_pkg::US_END;
            elem.offset = '0;
            elem.last   = 1'b1;
        end
    end

    assign adv      = (r_state == ST_RUN) && (!r_out_valid || i_pop);
    assign emit_end = adv && !fixed_phase && !tex_phase;
    assign load     = !i_q_empty && ((r_state == ST_IDLE) || emit_end);
    assign o_q_pop  = load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit_end && !load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= elem;
        end
        if (load) begin
            r_desc   <= i_q_data;
            r_pend   <= i_q_data.present;
            r_tex    <= '0;
            r_codes  <= i_q_data.tex_codes;
            r_offset <= '0;
        end else if (adv && fixed_phase) begin
            r_pend   <= r_pend & ~(vfwd_pkg::SLOTS'(1) << sel);
            r_offset <= r_offset + {4'b0000, vfwd_pkg::type_bytes(elem.etype)};
        end else if (adv && tex_phase) begin
            r_tex    <= r_tex + 4'd1;
            r_codes  <= {2'b00, r_codes[15:2]};
            r_offset <= r_offset + {4'b0000, vfwd_pkg::type_bytes(elem.etype)};
        end
    end

    assign o_empty = !r_out_valid;
    assign o_elem  = r_out;

endmodule

/* design/vertex_format_word_decoder_unit.sv */
// Vertex format word decoder: turns one flexible-vertex-format word into
// its ordered vertex element list.
// Input side is a queue: drive i_format_word with push high; the word is
// taken as a beat on a rising edge where push is high and full is low.
// Result side is a queue too: while empty is low the oldest element sits on
// the o_ ports; raise pop to take it. Each element carries type, usage,
// usage index and byte offset; the closing end element has o_end_of_list set.
// The first element of a word passes the front register, the descriptor queue,
// the back-end descriptor register and the output register to the ports.
// Throughput: one element per cycle from the back-end sequencer unless the
// receiver stalls, one per fixed element, texture set and end element; the
// next word is loaded in the cycle its predecessor's end element goes out.
// The front register and a two-deep descriptor queue let the front keep
// taking words while the back end works through a long list.
// When the receiver stalls, the output register holds its element and the
// sequencer waits; back-pressure then fills the queue and raises full.
// Synchronous reset empties every stage; no configuration is held.
module vertex_format_word_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_format_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_element_type,
    output logic [3:0]  o_element_usage,
    output logic [3:0]  o_usage_index,
    output logic [8:0]  o_byte_offset,
    output logic        o_end_of_list
);

    logic            fq_push;
    vfwd_pkg::t_desc fq_data;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    vfwd_pkg::t_desc q_head;
    vfwd_pkg::t_elem elem;

    // classify the word into a descriptor
    vfwd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_format_word (i_format_word),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_q_push      (fq_push),
        .o_q_data      (fq_data)
    );

    // hold descriptors until the back end is free
    vfwd_desc_q u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    // step through the elements, one beat per cycle while the output is not stalled
    vfwd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_elem    (elem)
    );

    assign o_element_type  = elem.etype;
    assign o_element_usage = elem.usage;
    assign o_usage_index   = elem.uidx;
    assign o_byte_offset   = elem.offset;
    assign o_end_of_list   = elem.last;

endmodule
